@@ hw/rtl/nnc_pkg.sv @@
// ----------------------------------------------------------------------------
// nnc_pkg
// shared constants and types of the nearest neighbor classifier
// ----------------------------------------------------------------------------
package nnc_pkg;

  localparam int NUM_CLASSES     = 10;
  localparam int TRAIN_PER_CLASS = 16;
  localparam int IMAGE_BYTES     = 3072;

  localparam int NUM_TRAIN = NUM_CLASSES * TRAIN_PER_CLASS;
  localparam int NUM_WORDS = NUM_TRAIN * IMAGE_BYTES;

  // port widths
  localparam int CLASS_IDX_W = 4;
  localparam int TRAIN_IDX_W = 4;
  localparam int BYTE_IDX_W  = 12;
  localparam int PIXEL_W     = 8;
  localparam int LABEL_W     = 4;
  localparam int DIST_W      = 28;
  localparam int SQ_W        = 2 * PIXEL_W;

  // internal widths
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int TR_W   = (TRAIN_PER_CLASS > 1) ? $clog2(TRAIN_PER_CLASS) : 1;
  localparam int SLOT_W = (NUM_TRAIN > 1) ? $clog2(NUM_TRAIN) : 1;
  localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // cycles from the last accumulator issue until the best candidate is final
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = 2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  typedef struct packed {
    logic             load_we;
    logic             test_start;
    logic             issue;
    logic [TR_W-1:0]  issue_tr;
    logic [CLS_W-1:0] issue_c;
    logic             issue_first;
    logic             clear;
  } nnc_cmd_t;

endpackage

@@ hw/rtl/nnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// nnc_ctrl
// sequencer: takes items, sweeps all training images per test byte, emits
// ----------------------------------------------------------------------------
module nnc_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              req_type,
  input  logic [nnc_pkg::CLASS_IDX_W-1:0]   class_idx,
  input  logic [nnc_pkg::TRAIN_IDX_W-1:0]   train_idx,
  input  logic [nnc_pkg::BYTE_IDX_W-1:0]    byte_idx,
  output logic                              busy,
  output logic                              done,
  output nnc_pkg::nnc_cmd_t                 cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SWEEP,
    DRAIN
  } state_t;

  state_t                       state;
  logic [nnc_pkg::TR_W-1:0]     tr;
  logic [nnc_pkg::CLS_W-1:0]    c;
  logic [nnc_pkg::DRAIN_W-1:0]  drain_cnt;
  logic                         last_byte;

  logic accept;
  logic load_ok;
  logic test_ok;
  logic c_wrap;
  logic tr_wrap;
  logic drain_end;

  assign accept  = start && (state == IDLE);
  assign load_ok = (32'(class_idx) < nnc_pkg::NUM_CLASSES) &&
                   (32'(train_idx) < nnc_pkg::TRAIN_PER_CLASS) &&
                   (32'(byte_idx) < nnc_pkg::IMAGE_BYTES);
  assign test_ok = 32'(byte_idx) < nnc_pkg::IMAGE_BYTES;

  assign c_wrap    = 32'(c) == nnc_pkg::NUM_CLASSES - 1;
  assign tr_wrap   = 32'(tr) == nnc_pkg::TRAIN_PER_CLASS - 1;
  assign drain_end = 32'(drain_cnt) == nnc_pkg::DRAIN_CYCLES - 1;

  assign busy = (state != IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load_we     = accept && (req_type == nnc_pkg::REQ_LOAD) && load_ok;
    cmd.test_start  = accept && (req_type == nnc_pkg::REQ_TEST) && test_ok;
    cmd.issue       = (state == SWEEP);
    cmd.issue_tr    = tr;
    cmd.issue_c     = c;
    cmd.issue_first = (tr == '0) && (c == '0);
    cmd.clear       = (state == DRAIN) && drain_end && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      tr        <= '0;
      c         <= '0;
      drain_cnt <= '0;
      last_byte <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (cmd.test_start) begin
            state     <= SWEEP;
            tr        <= '0;
            c         <= '0;
            last_byte <= 32'(byte_idx) == nnc_pkg::IMAGE_BYTES - 1;
          end
        end
        SWEEP: begin
          // classes inner, training images outer
          if (c_wrap) begin
            c <= '0;
            if (tr_wrap) begin
              state     <= DRAIN;
              drain_cnt <= '0;
            end else begin
              tr <= tr + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        DRAIN: begin
          if (drain_end) begin
            state <= IDLE;
            done  <= last_byte;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/nnc_dpath.sv @@
// ----------------------------------------------------------------------------
// nnc_dpath
// training store, distance accumulators, squared difference unit, min search
// ----------------------------------------------------------------------------
module nnc_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  nnc_pkg::nnc_cmd_t                 cmd,
  input  logic [nnc_pkg::CLASS_IDX_W-1:0]   class_idx,
  input  logic [nnc_pkg::TRAIN_IDX_W-1:0]   train_idx,
  input  logic [nnc_pkg::BYTE_IDX_W-1:0]    byte_idx,
  input  logic [nnc_pkg::PIXEL_W-1:0]       pixel,
  output logic [nnc_pkg::LABEL_W-1:0]       label,
  output logic [nnc_pkg::DIST_W-1:0]        best_distance
);

  localparam int SUM_W = nnc_pkg::DIST_W + 1;

  logic [nnc_pkg::PIXEL_W-1:0] train_mem [nnc_pkg::NUM_WORDS];
  logic [nnc_pkg::DIST_W-1:0]  acc_mem   [nnc_pkg::NUM_TRAIN];
  logic [nnc_pkg::NUM_TRAIN-1:0] acc_vld;

  // latched test item
  logic [nnc_pkg::BYTE_IDX_W-1:0] test_pos;
  logic [nnc_pkg::PIXEL_W-1:0]    test_px;

  logic [nnc_pkg::SLOT_W-1:0] wr_slot;
  logic [nnc_pkg::ADDR_W-1:0] wr_addr;
  logic [nnc_pkg::SLOT_W-1:0] rd_slot;
  logic [nnc_pkg::ADDR_W-1:0] rd_addr;

  assign wr_slot = nnc_pkg::SLOT_W'(32'(class_idx) * nnc_pkg::TRAIN_PER_CLASS
                                    + 32'(train_idx));
  assign wr_addr = nnc_pkg::ADDR_W'(32'(wr_slot) * nnc_pkg::IMAGE_BYTES
                                    + 32'(byte_idx));
  assign rd_slot = nnc_pkg::SLOT_W'(32'(cmd.issue_c) * nnc_pkg::TRAIN_PER_CLASS
                                    + 32'(cmd.issue_tr));
  assign rd_addr = nnc_pkg::ADDR_W'(32'(rd_slot) * nnc_pkg::IMAGE_BYTES
                                    + 32'(test_pos));

  // stage 1: memory reads
  logic                         v1;
  logic                         first1;
  logic [nnc_pkg::SLOT_W-1:0]   slot1;
  logic [nnc_pkg::CLS_W-1:0]    c1;
  logic [nnc_pkg::PIXEL_W-1:0]  tpx1;
  logic [nnc_pkg::DIST_W-1:0]   acc1;
  logic                         vld1;

  // stage 2: squared difference
  logic                         v2;
  logic                         first2;
  logic [nnc_pkg::SLOT_W-1:0]   slot2;
  logic [nnc_pkg::CLS_W-1:0]    c2;
  logic [nnc_pkg::SQ_W-1:0]     sq2;
  logic [nnc_pkg::DIST_W-1:0]   acc2;

  // stage 3: updated distance
  logic                         v3;
  logic                         first3;
  logic [nnc_pkg::CLS_W-1:0]    c3;
  logic [nnc_pkg::DIST_W-1:0]   dist3;

  logic [nnc_pkg::CLS_W-1:0]    best_c;
  logic [nnc_pkg::DIST_W-1:0]   best_d;

  logic [nnc_pkg::PIXEL_W-1:0]  diff1;
  logic [SUM_W-1:0]             sum2;
  logic [nnc_pkg::DIST_W-1:0]   sat2;

  assign diff1 = (tpx1 > test_px) ? (tpx1 - test_px) : (test_px - tpx1);
  assign sum2  = {1'b0, acc2} + SUM_W'(sq2);
  assign sat2  = sum2[SUM_W-1] ? nnc_pkg::DIST_MAX : sum2[nnc_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      train_mem[wr_addr] <= pixel;
    end
    tpx1 <= train_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      acc_mem[slot2] <= sat2;
    end
    acc1 <= acc_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.test_start) begin
      test_pos <= byte_idx;
      test_px  <= pixel;
    end
    first1 <= cmd.issue_first;
    slot1  <= rd_slot;
    c1     <= cmd.issue_c;
    vld1   <= acc_vld[rd_slot];
    first2 <= first1;
    slot2  <= slot1;
    c2     <= c1;
    sq2    <= diff1 * diff1;
    acc2   <= vld1 ? acc1 : '0;
    first3 <= first2;
    c3     <= c2;
    dist3  <= sat2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      acc_vld <= '0;
      best_c  <= '0;
      best_d  <= '0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      if (cmd.clear) begin
        acc_vld <= '0;
      end else if (v2) begin
        acc_vld[slot2] <= 1'b1;
      end
      // first candidate seeds the best, later ones must be strictly smaller
      if (v3 && (first3 || (dist3 < best_d))) begin
        best_c <= c3;
        best_d <= dist3;
      end
    end
  end

  assign label         = nnc_pkg::LABEL_W'(best_c);
  assign best_distance = best_d;

endmodule

@@ hw/rtl/nearest_neighbor_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_classifier_unit
// one-nearest-neighbor classifier over byte images, squared euclidean metric
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A training byte
// (req_type 0) is written in the cycle it is taken and busy stays low. A
// test byte (req_type 1) keeps busy high while one shared squared-difference
// unit and the single accumulator memory update one training-image distance
// per cycle for all NUM_TRAIN images, then a three stage pipeline drains.
// On the test byte at the last byte position, done is high for exactly one
// cycle after busy falls, with label and best_distance valid in that cycle;
// the result cannot be held off, so it must be captured then. A test byte
// beyond the image gives no result.
module nearest_neighbor_classifier_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic [nnc_pkg::CLASS_IDX_W-1:0]   class_idx,
  input  logic [nnc_pkg::TRAIN_IDX_W-1:0]   train_idx,
  input  logic [nnc_pkg::BYTE_IDX_W-1:0]    byte_idx,
  input  logic [nnc_pkg::PIXEL_W-1:0]       pixel,
  output logic                              done,
  output logic [nnc_pkg::LABEL_W-1:0]       label,
  output logic [nnc_pkg::DIST_W-1:0]        best_distance
);

  nnc_pkg::nnc_cmd_t cmd;

  nnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .class_idx (class_idx),
    .train_idx (train_idx),
    .byte_idx  (byte_idx),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  nnc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .class_idx     (class_idx),
    .train_idx     (train_idx),
    .byte_idx      (byte_idx),
    .pixel         (pixel),
    .label         (label),
    .best_distance (best_distance)
  );

endmodule
